// ----- design/mfn_pkg.sv -----
// Shared types, codes and helper functions of the maze flood-fill navigator.
package mfn_pkg;

    // Absolute directions, also the bit positions in a cell's wall set.
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // Move codes of a result.
    localparam logic [1:0] MOVE_FWD   = 2'd0;
    localparam logic [1:0] MOVE_LEFT  = 2'd1;
    localparam logic [1:0] MOVE_RIGHT = 2'd2;
    localparam logic [1:0] MOVE_BACK  = 2'd3;

    localparam logic [7:0] DIST_MAX = 8'd255;

    // Input and output transaction widths.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clr;       // write one reset entry of the cell maps
        logic       load;      // take an input transaction
        logic       wr_wall;   // write the sensed wall set of the current cell
        logic       ev_rd;     // read step of a cell evaluation
        logic       rd_prev;   // read the previous cell's distance
        logic       seed_wr;   // write previous distance plus one to the cell
        logic       fix_wr;    // write smallest open neighbour plus one
        logic       push;      // push step of a cell and its open neighbours
        logic       pop;       // read the queue head
        logic       pop_cap;   // take the popped cell as current
        logic       cur_cell;  // make the reached cell current again
        logic       drop_left; // flag entries still queued as dropped
        logic       out_load;  // load the result register
        logic [2:0] step;      // 0: current cell, 1 to 4: neighbour N, E, S, W
    } mfn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic consistent;
        logic pop_ok;
    } mfn_sts_t;

    function automatic logic [1:0] move_code(input logic [1:0] choice,
                                             input logic [1:0] heading);
        logic [1:0] rel;
        rel = choice - heading;
        case (rel)
            2'd0: begin
                move_code = MOVE_FWD;
            end
            2'd3: begin
                move_code = MOVE_LEFT;
            end
            2'd1: begin
                move_code = MOVE_RIGHT;
            end
            default: begin
                move_code = MOVE_BACK;
            end
        endcase
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == DIST_MAX) ? DIST_MAX : v + 8'd1;
    endfunction

endpackage

// ----- design/maze_floodfill_navigator.sv -----
// Top level of the maze flood-fill navigator.
//
// The s_ channel takes one transaction for each cell the robot reaches: its
// position, the previous cell, the heading and the three sensed walls. The m_
// channel returns one transaction per input with the next move and a flag
// that says reflood entries were dropped.
// After reset the block sweeps the wall and distance maps once, one cell per
// cycle, with s_tready low; the distance map starts at the distance to the
// centre. The time an item takes grows when the reached cell is reseeded from
// the previous cell, with each cell popped from the reflood queue and with each
// cell whose distance is corrected; every map access goes through the single
// read port of the cell memories, and the reflood loop is limited to
// 16*QUEUE_DEPTH pops. Items are handled one at a time. A result waits in the
// output register until m_tready; the next input is taken meanwhile and its
// reflood runs, but its result waits for the output register to empty.
module maze_floodfill_navigator #(
    parameter int GRID_SIDE   = 16,
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cell_x[3:0], cell_y[7:4], prev_x[11:8], prev_y[15:12], heading[17:16],
    // wall_left[18], wall_right[19], wall_front[20], zero[23:21]
    input  logic [mfn_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // move[1:0], queue_overflow[2], zero[7:3]
    output logic [mfn_pkg::M_TDATA_W-1:0] m_tdata
);

    mfn_pkg::mfn_cmd_t cmd;
    mfn_pkg::mfn_sts_t sts;

    mfn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mfn_dp #(
        .GRID_SIDE   (GRID_SIDE),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

// ----- design/mfn_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module mfn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mfn_dp.sv -----
// Datapath of the navigator: cell maps, reflood queue, evaluation and result registers.
module mfn_dp #(
    parameter int GRID_SIDE   = 16,
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mfn_pkg::mfn_cmd_t             cmd,
    output mfn_pkg::mfn_sts_t             sts,
    input  logic [mfn_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [mfn_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CW        = $clog2(GRID_SIDE);
    localparam int AW        = 2 * CW;
    localparam int CELLS     = 1 << AW;
    localparam int QAW       = $clog2(QUEUE_DEPTH);
    localparam int QCW       = $clog2(QUEUE_DEPTH + 1);
    localparam int POP_LIMIT = 16 * QUEUE_DEPTH;
    localparam int PCW       = $clog2(POP_LIMIT + 1);
    localparam int HALF      = GRID_SIDE / 2;

    function automatic logic [CW-1:0] clamp(input logic [3:0] v);
        logic [5:0] w;
        w = {2'b00, v};
        if (w >= 6'(GRID_SIDE)) begin
            w = 6'(GRID_SIDE - 1);
        end
        clamp = w[CW-1:0];
    endfunction

    function automatic logic [7:0] half_dist(input logic [CW-1:0] c);
        logic [7:0] w;
        w = 8'(c);
        half_dist = (w < 8'(HALF)) ? 8'(HALF - 1) - w : w - 8'(HALF);
    endfunction

    logic [AW-1:0]  cell_reg, prev_reg, cur_reg, clr_reg;
    logic [1:0]     hdg_reg;
    logic [3:0]     walls_in_reg, wall_reg;
    logic [7:0]     val_reg;
    logic [7:0]     nd_reg [4];
    logic           cap_vld_reg;
    logic [2:0]     cap_sel_reg;
    logic [QAW-1:0] head_reg, tail_reg;
    logic [QCW-1:0] count_reg;
    logic [PCW-1:0] pops_reg;
    logic           dropped_reg;
    logic [1:0]     move_reg;
    logic           ovf_reg;

    logic [CW-1:0]  cx, cy, in_x, in_y, in_px, in_py, clr_x, clr_y;
    logic [AW-1:0]  nb_addr [4];
    logic [3:0]     ongrid, open, back;
    logic [2:0]     sm1;
    logic [1:0]     sidx;
    logic           match, consistent, multi, full, push_do, q_we;
    logic [8:0]     best, cbest;
    logic [7:0]     new_dist, reset_dist, wall_rd_unused_dist;
    logic [1:0]     choice;
    logic [3:0]     wall_rdata, in_walls, h1, h3;
    logic [7:0]     dist_rdata, dist_wdata;
    logic [AW-1:0]  raddr, waddr, push_data, q_rdata;
    logic [1:0]     in_hdg;

    assign cx = cur_reg[CW-1:0];
    assign cy = cur_reg[AW-1:CW];

    assign nb_addr[mfn_pkg::DIR_N] = {cy + CW'(1), cx};
    assign nb_addr[mfn_pkg::DIR_E] = {cy, cx + CW'(1)};
    assign nb_addr[mfn_pkg::DIR_S] = {cy - CW'(1), cx};
    assign nb_addr[mfn_pkg::DIR_W] = {cy, cx - CW'(1)};
    assign ongrid[mfn_pkg::DIR_N]  = (cy != CW'(GRID_SIDE - 1));
    assign ongrid[mfn_pkg::DIR_E]  = (cx != CW'(GRID_SIDE - 1));
    assign ongrid[mfn_pkg::DIR_S]  = (cy != '0);
    assign ongrid[mfn_pkg::DIR_W]  = (cx != '0);
    assign open = ~wall_reg & ongrid;

    // Input unpacking; the sensed sides are turned into absolute directions.
    assign in_x   = clamp(s_tdata[3:0]);
    assign in_y   = clamp(s_tdata[7:4]);
    assign in_px  = clamp(s_tdata[11:8]);
    assign in_py  = clamp(s_tdata[15:12]);
    assign in_hdg = s_tdata[17:16];
    assign h1     = 4'(1) << (in_hdg + 2'd1);
    assign h3     = 4'(1) << (in_hdg + 2'd3);
    assign in_walls = ({4{s_tdata[20]}} & (4'(1) << in_hdg))
                    | ({4{s_tdata[19]}} & h1)
                    | ({4{s_tdata[18]}} & h3);

    // Consistency, smallest open neighbour and the move choice.
    always_comb begin
        match = 1'b0;
        best  = 9'd256;
        cbest = 9'd256;
        choice = mfn_pkg::DIR_N;
        multi = ((open & (open - 4'd1)) != 4'd0);
        for (int d = 0; d < 4; d++) begin
            back[d] = open[d] && (nb_addr[d] == prev_reg);
            if (open[d] && ({1'b0, nd_reg[d]} + 9'd1 == {1'b0, val_reg})) begin
                match = 1'b1;
            end
            if (open[d] && ({1'b0, nd_reg[d]} < best)) begin
                best = {1'b0, nd_reg[d]};
            end
        end
        for (int d = 0; d < 4; d++) begin
            if (open[d] && !(multi && back[d]) && ({1'b0, nd_reg[d]} < cbest)) begin
                cbest  = {1'b0, nd_reg[d]};
                choice = 2'(d);
            end
        end
    end

    assign consistent = (val_reg == 8'd0) || (val_reg == mfn_pkg::DIST_MAX)
                      || (open == 4'd0) || match;
    assign new_dist = (best >= 9'(mfn_pkg::DIST_MAX)) ? mfn_pkg::DIST_MAX
                                                      : best[7:0] + 8'd1;

    assign clr_x      = clr_reg[CW-1:0];
    assign clr_y      = clr_reg[AW-1:CW];
    assign reset_dist = half_dist(clr_x) + half_dist(clr_y);
    assign wall_rd_unused_dist = 8'd0;

    assign sm1  = cmd.step - 3'd1;
    assign sidx = sm1[1:0];

    always_comb begin
        if (cmd.rd_prev) begin
            raddr = prev_reg;
        end else if (cmd.step == 3'd0) begin
            raddr = cur_reg;
        end else begin
            raddr = nb_addr[sidx];
        end
    end

    assign waddr = cmd.clr ? clr_reg : cur_reg;

    always_comb begin
        if (cmd.clr) begin
            dist_wdata = reset_dist;
        end else if (cmd.seed_wr) begin
            dist_wdata = mfn_pkg::sat_inc(dist_rdata);
        end else begin
            dist_wdata = new_dist | wall_rd_unused_dist;
        end
    end

    mfn_ram #(.WIDTH(4), .DEPTH(CELLS)) u_wall_ram (
        .aclk  (aclk),
        .we    (cmd.clr | cmd.wr_wall),
        .waddr (waddr),
        .wdata (cmd.clr ? 4'd0 : walls_in_reg),
        .raddr (raddr),
        .rdata (wall_rdata)
    );

    mfn_ram #(.WIDTH(8), .DEPTH(CELLS)) u_dist_ram (
        .aclk  (aclk),
        .we    (cmd.clr | cmd.seed_wr | cmd.fix_wr),
        .waddr (waddr),
        .wdata (dist_wdata),
        .raddr (raddr),
        .rdata (dist_rdata)
    );

    // Push step zero queues the current cell, later steps its open neighbours.
    assign push_data = (cmd.step == 3'd0) ? cur_reg : nb_addr[sidx];
    assign push_do   = cmd.push && ((cmd.step == 3'd0) || open[sidx]);
    assign full      = (count_reg >= QCW'(QUEUE_DEPTH));
    assign q_we      = push_do && !full;

    mfn_ram #(.WIDTH(AW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (push_data),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            cap_vld_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            pops_reg    <= '0;
            dropped_reg <= 1'b0;
        end else begin
            if (cmd.clr) begin
                clr_reg <= clr_reg + AW'(1);
            end
            cap_vld_reg <= cmd.ev_rd;
            if (cmd.load) begin
                head_reg    <= '0;
                tail_reg    <= '0;
                count_reg   <= '0;
                pops_reg    <= '0;
                dropped_reg <= 1'b0;
            end else if (cmd.pop) begin
                head_reg  <= (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QAW'(1);
                count_reg <= count_reg - QCW'(1);
                pops_reg  <= pops_reg + PCW'(1);
            end else if (push_do) begin
                if (full) begin
                    dropped_reg <= 1'b1;
                end else begin
                    tail_reg  <= (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + QAW'(1);
                    count_reg <= count_reg + QCW'(1);
                end
            end else if (cmd.drop_left && (count_reg != '0)) begin
                dropped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cell_reg     <= {in_y, in_x};
            cur_reg      <= {in_y, in_x};
            prev_reg     <= {in_py, in_px};
            hdg_reg      <= in_hdg;
            walls_in_reg <= in_walls;
        end else if (cmd.pop_cap) begin
            cur_reg <= q_rdata;
        end else if (cmd.cur_cell) begin
            cur_reg <= cell_reg;
        end
        if (cmd.ev_rd) begin
            cap_sel_reg <= cmd.step;
        end
        if (cap_vld_reg) begin
            if (cap_sel_reg == 3'd0) begin
                wall_reg <= wall_rdata;
                val_reg  <= dist_rdata;
            end else begin
                nd_reg[2'(cap_sel_reg - 3'd1)] <= dist_rdata;
            end
        end
        if (cmd.out_load) begin
            move_reg <= mfn_pkg::move_code(choice, hdg_reg);
            ovf_reg  <= dropped_reg;
        end
    end

    assign sts.clr_last   = (clr_reg == AW'(CELLS - 1));
    assign sts.consistent = consistent;
    assign sts.pop_ok     = (count_reg != '0) && (pops_reg < PCW'(POP_LIMIT));

    assign m_tdata = {5'd0, ovf_reg, move_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCW'(QUEUE_DEPTH))
        else $error("reflood queue count beyond its depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (count_reg != '0))
        else $error("pop from an empty reflood queue");

    a_full_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_do && full && !cmd.load) |=> dropped_reg)
        else $error("push onto a full queue not flagged");
`endif

endmodule

// ----- design/mfn_ctrl.sv -----
// Controller state machine of the navigator: sequences clearing, reflood and decision.
module mfn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mfn_pkg::mfn_sts_t sts,
    output mfn_pkg::mfn_cmd_t cmd
);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_WWALL   = 4'd2;
    localparam logic [3:0] ST_EVAL    = 4'd3;
    localparam logic [3:0] ST_EVAL_W  = 4'd4;
    localparam logic [3:0] ST_CHK     = 4'd5;
    localparam logic [3:0] ST_RD_PREV = 4'd6;
    localparam logic [3:0] ST_SEED    = 4'd7;
    localparam logic [3:0] ST_PUSH    = 4'd8;
    localparam logic [3:0] ST_LOOP    = 4'd9;
    localparam logic [3:0] ST_POP     = 4'd10;
    localparam logic [3:0] ST_POP_CAP = 4'd11;
    localparam logic [3:0] ST_FIX     = 4'd12;
    localparam logic [3:0] ST_DONE    = 4'd13;

    localparam logic [1:0] MODE_ARRIVE  = 2'd0;
    localparam logic [1:0] MODE_REFLOOD = 2'd1;
    localparam logic [1:0] MODE_DECIDE  = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] mode_reg, mode_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        mode_next     = mode_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.step      = step_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WWALL;
                end
            end
            ST_WWALL: begin
                cmd.wr_wall = 1'b1;
                mode_next   = MODE_ARRIVE;
                step_next   = 3'd0;
                state_next  = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.ev_rd = 1'b1;
                if (step_reg == 3'd4) begin
                    state_next = ST_EVAL_W;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_EVAL_W: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                step_next = 3'd0;
                case (mode_reg)
                    MODE_ARRIVE: begin
                        state_next = sts.consistent ? ST_PUSH : ST_RD_PREV;
                    end
                    MODE_REFLOOD: begin
                        state_next = sts.consistent ? ST_LOOP : ST_FIX;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RD_PREV: begin
                cmd.rd_prev = 1'b1;
                state_next  = ST_SEED;
            end
            ST_SEED: begin
                cmd.seed_wr = 1'b1;
                step_next   = 3'd0;
                state_next  = ST_PUSH;
            end
            ST_FIX: begin
                cmd.fix_wr = 1'b1;
                step_next  = 3'd0;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
                if (step_reg == 3'd4) begin
                    state_next = ST_LOOP;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_LOOP: begin
                step_next = 3'd0;
                if (sts.pop_ok) begin
                    state_next = ST_POP;
                end else begin
                    cmd.drop_left = 1'b1;
                    cmd.cur_cell  = 1'b1;
                    mode_next     = MODE_DECIDE;
                    state_next    = ST_EVAL;
                end
            end
            ST_POP: begin
                cmd.pop    = 1'b1;
                state_next = ST_POP_CAP;
            end
            ST_POP_CAP: begin
                cmd.pop_cap = 1'b1;
                mode_next   = MODE_REFLOOD;
                step_next   = 3'd0;
                state_next  = ST_EVAL;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            step_reg     <= 3'd0;
            mode_reg     <= MODE_ARRIVE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded while a result is still held");

    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished decision did not raise a result");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL || state_reg == ST_PUSH) |-> (step_reg <= 3'd4))
        else $error("evaluation or push step out of range");
`endif

endmodule

// ----- bench/maze_floodfill_navigator_test.sv -----
// Self-checking stream testbench for the maze flood-fill navigator.
`timescale 1ns / 100ps

module maze_floodfill_navigator_test;

    localparam int SIDE = 16;
    localparam int HALF = SIDE / 2;
    localparam int CELLS = SIDE * SIDE;
    localparam int QDEPTH = 1024;
    localparam int POP_CAP = 16 * QDEPTH;
    localparam int WATCHDOG_LIMIT = 1500000;

    typedef struct packed {
        logic       wall_front;
        logic       wall_right;
        logic       wall_left;
        logic [1:0] heading;
        logic [3:0] prev_y;
        logic [3:0] prev_x;
        logic [3:0] cell_y;
        logic [3:0] cell_x;
    } arrival_t;

    typedef struct packed {
        logic       queue_overflow;
        logic [1:0] move;
    } decision_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [mfn_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [mfn_pkg::M_TDATA_W-1:0] m_tdata;

    arrival_t pending_arrivals[$];
    decision_t expected_moves[$];
    int errors = 0;
    int idle_cycles = 0;

    // Mirror of the navigator's maps and reflood queue.
    logic [3:0] wall_mirror[CELLS];
    logic [7:0] dist_mirror[CELLS];
    int refl_q[QDEPTH];
    int q_head, q_tail, q_count;
    bit q_dropped;

    maze_floodfill_navigator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic bit side_open(int c, int d, output int n);
        int x, y;
        x = c % SIDE;
        y = c / SIDE;
        n = 0;
        if (wall_mirror[c][d]) return 0;
        case (d[1:0])
            mfn_pkg::DIR_N: begin
                if (y + 1 >= SIDE) return 0;
                y++;
            end
            mfn_pkg::DIR_E: begin
                if (x + 1 >= SIDE) return 0;
                x++;
            end
            mfn_pkg::DIR_S: begin
                if (y == 0) return 0;
                y--;
            end
            default: begin
                if (x == 0) return 0;
                x--;
            end
        endcase
        n = y * SIDE + x;
        return 1;
    endfunction

    function automatic bit cell_settled(int c);
        int n;
        bit any_open;
        any_open = 0;
        if (dist_mirror[c] == 8'd0 || dist_mirror[c] == mfn_pkg::DIST_MAX) return 1;
        for (int d = 0; d < 4; d++) begin
            if (side_open(c, d, n)) begin
                any_open = 1;
                if (int'(dist_mirror[n]) + 1 == int'(dist_mirror[c])) return 1;
            end
        end
        return !any_open;
    endfunction

    function automatic void settle_cell(int c);
        int n, lowest;
        lowest = 256;
        for (int d = 0; d < 4; d++)
            if (side_open(c, d, n) && int'(dist_mirror[n]) < lowest)
                lowest = int'(dist_mirror[n]);
        if (lowest < 256)
            dist_mirror[c] = (lowest + 1 > 255) ? mfn_pkg::DIST_MAX : 8'(lowest + 1);
    endfunction

    function automatic void enqueue_cell(int c);
        if (q_count >= QDEPTH) begin
            q_dropped = 1;
            return;
        end
        refl_q[q_tail] = c;
        q_tail = (q_tail + 1 >= QDEPTH) ? 0 : q_tail + 1;
        q_count++;
    endfunction

    function automatic void enqueue_with_open(int c);
        int n;
        enqueue_cell(c);
        for (int d = 0; d < 4; d++)
            if (side_open(c, d, n)) enqueue_cell(n);
    endfunction

    function automatic decision_t navigate(arrival_t a);
        int at_cell, prev, h, n, pops, cur, open_cnt, lowest, choice, back_dir, seed;
        bit back_ok;
        decision_t r;
        at_cell = int'(a.cell_y) * SIDE + int'(a.cell_x);
        prev = int'(a.prev_y) * SIDE + int'(a.prev_x);
        h = int'(a.heading);
        wall_mirror[at_cell] = '0;
        if (a.wall_front) wall_mirror[at_cell][h] = 1'b1;
        if (a.wall_right) wall_mirror[at_cell][(h + 1) % 4] = 1'b1;
        if (a.wall_left) wall_mirror[at_cell][(h + 3) % 4] = 1'b1;
        q_head = 0;
        q_tail = 0;
        q_count = 0;
        q_dropped = 0;
        if (!cell_settled(at_cell)) begin
            seed = int'(dist_mirror[prev]) + 1;
            dist_mirror[at_cell] = (seed > 255) ? mfn_pkg::DIST_MAX : 8'(seed);
        end
        enqueue_with_open(at_cell);
        pops = 0;
        while (q_count > 0 && pops < POP_CAP) begin
            cur = refl_q[q_head] % CELLS;
            q_head = (q_head + 1 >= QDEPTH) ? 0 : q_head + 1;
            q_count--;
            pops++;
            if (!cell_settled(cur)) begin
                settle_cell(cur);
                enqueue_with_open(cur);
            end
        end
        if (q_count > 0) q_dropped = 1;
        open_cnt = 0;
        back_ok = 0;
        back_dir = 0;
        for (int d = 0; d < 4; d++) begin
            if (side_open(at_cell, d, n)) begin
                open_cnt++;
                if (n == prev) begin
                    back_ok = 1;
                    back_dir = d;
                end
            end
        end
        lowest = 256;
        choice = int'(mfn_pkg::DIR_N);
        for (int d = 0; d < 4; d++) begin
            if (!side_open(at_cell, d, n)) continue;
            if (open_cnt > 1 && back_ok && d == back_dir) continue;
            if (int'(dist_mirror[n]) < lowest) begin
                lowest = int'(dist_mirror[n]);
                choice = d;
            end
        end
        case (2'(choice - h))
            2'd0: r.move = mfn_pkg::MOVE_FWD;
            2'd3: r.move = mfn_pkg::MOVE_LEFT;
            2'd1: r.move = mfn_pkg::MOVE_RIGHT;
            default: r.move = mfn_pkg::MOVE_BACK;
        endcase
        r.queue_overflow = q_dropped;
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
        return $urandom_range(10, 60);
    endfunction

    // Input driver: a new transaction is presented once the previous one is taken.
    int send_gap = 0;
    always @(posedge aclk) begin
        logic next_valid;
        arrival_t a;
        next_valid = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_moves.push_back(navigate(arrival_t'(s_tdata[20:0])));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_arrivals.size() > 0) begin
                    a = pending_arrivals.pop_front();
                    s_tdata <= {3'b000, a};
                    next_valid = 1'b1;
                    send_gap <= pick_gap();
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // Result monitor with random back-pressure.
    int stall_left = 0;
    always @(posedge aclk) begin
        decision_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_moves.size() == 0) begin
                    $error("result transaction with no expectation: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_moves.pop_front();
                    if (m_tdata[1:0] !== want.move) begin
                        $error("move: expected %0d, got %0d", want.move, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[2] !== want.queue_overflow) begin
                        $error("queue_overflow: expected %0d, got %0d",
                               want.queue_overflow, m_tdata[2]);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                stall_left <= pick_gap();
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic arrival_t make_arrival(int cx, int cy, int px, int py, int h,
                                              bit wl, bit wr, bit wf);
        arrival_t a;
        a.cell_x = 4'(cx);
        a.cell_y = 4'(cy);
        a.prev_x = 4'(px);
        a.prev_y = 4'(py);
        a.heading = 2'(h);
        a.wall_left = wl;
        a.wall_right = wr;
        a.wall_front = wf;
        return a;
    endfunction

    // Hidden maze the random walk senses; edges of the grid read as walls.
    bit maze_wall[CELLS][4];

    function automatic bit blocked(int x, int y, int d);
        if (maze_wall[y * SIDE + x][d]) return 1;
        case (d)
            0: return y == SIDE - 1;
            1: return x == SIDE - 1;
            2: return y == 0;
            default: return x == 0;
        endcase
    endfunction

    initial begin
        int x, y, px, py, h, d, dx, dy;
        arrival_t a;
        // The mirror starts as the block does after reset.
        for (int cy = 0; cy < SIDE; cy++) begin
            for (int cx = 0; cx < SIDE; cx++) begin
                dx = (cx < HALF) ? HALF - 1 - cx : cx - HALF;
                dy = (cy < HALF) ? HALF - 1 - cy : cy - HALF;
                dist_mirror[cy * SIDE + cx] = (dx + dy > 255) ? mfn_pkg::DIST_MAX
                                                              : 8'(dx + dy);
                wall_mirror[cy * SIDE + cx] = 4'd0;
            end
        end
        // Corners, all headings and wall patterns, a sealed dead end, far jumps.
        pending_arrivals.push_back(make_arrival(0, 0, 0, 1, int'(mfn_pkg::DIR_S), 0, 0, 0));
        pending_arrivals.push_back(make_arrival(15, 15, 14, 15, int'(mfn_pkg::DIR_E), 1, 1, 1));
        pending_arrivals.push_back(make_arrival(15, 0, 15, 1, int'(mfn_pkg::DIR_S), 0, 1, 1));
        pending_arrivals.push_back(make_arrival(0, 15, 1, 15, int'(mfn_pkg::DIR_W), 1, 0, 1));
        pending_arrivals.push_back(make_arrival(0, 15, 0, 14, int'(mfn_pkg::DIR_S), 1, 1, 1));
        for (int i = 0; i < 8; i++)
            pending_arrivals.push_back(make_arrival(7 + i % 2, 7 + i / 4, 7, 6, i % 4,
                                                    i[0], i[1], i[2]));
        pending_arrivals.push_back(make_arrival(3, 12, 15, 0, int'(mfn_pkg::DIR_N), 1, 1, 0));
        pending_arrivals.push_back(make_arrival(12, 3, 12, 3, int'(mfn_pkg::DIR_W), 0, 0, 1));
        pending_arrivals.push_back(make_arrival(5, 5, 9, 13, int'(mfn_pkg::DIR_E), 1, 0, 1));

        for (int c = 0; c < CELLS; c++)
            for (int k = 0; k < 4; k++) maze_wall[c][k] = ($urandom_range(0, 9) < 3);
        x = 0;
        y = 0;
        h = int'(mfn_pkg::DIR_N);
        px = 0;
        py = 0;
        for (int i = 0; i < 450; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                a = arrival_t'(21'($urandom()));
            end else begin
                a = make_arrival(x, y, px, py, h, blocked(x, y, (h + 3) % 4),
                                 blocked(x, y, (h + 1) % 4), blocked(x, y, h));
                // Pick an open direction at random; turning back is always allowed.
                d = (h + 2) % 4;
                for (int t = 0; t < 4; t++) begin
                    int k;
                    k = $urandom_range(0, 3);
                    if (!blocked(x, y, k)) begin
                        d = k;
                        break;
                    end
                end
                if (blocked(x, y, d)) d = (h + 2) % 4;
                px = x;
                py = y;
                case (d)
                    0: y = (y < SIDE - 1) ? y + 1 : y;
                    1: x = (x < SIDE - 1) ? x + 1 : x;
                    2: y = (y > 0) ? y - 1 : y;
                    default: x = (x > 0) ? x - 1 : x;
                endcase
                h = d;
            end
            pending_arrivals.push_back(a);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // Sampled at the falling edge so that the driver's updates have settled.
        while (pending_arrivals.size() > 0 || s_tvalid || expected_moves.size() > 0)
            @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_moves.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
